>>> rtl/gebc_pkg.sv
// Shared types, constants and command/status structs of the band-pass cascade equalizer.
// Depends on nothing; every other file but gebc_ram imports it.
package gebc_pkg;

    localparam int NUM_BANDS    = 10;
    localparam int NUM_CHANNELS = 8;
    localparam int ROWS         = NUM_BANDS * NUM_CHANNELS;
    localparam int ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIDX_W       = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int CIDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BCNT_W       = $clog2(NUM_BANDS + 1);

    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [3:0]         ACTIVE_BANDS_RESET = 4'd10;
    localparam logic signed [32:0] MA_SECOND_TAP      = -33'sd263455;
    localparam logic [31:0]        RECOVER_FACTOR     = 32'd2147498251;
    localparam logic [31:0]        UNITY_ATTEN        = 32'h8000_0000;
    localparam logic [5:0]         DIV_STEPS          = 6'd32;

    // Clip limits of the Q.45 attenuated value and the matching dividends
    localparam logic signed [66:0] LIM_HI     = 67'sd32767 <<< 45;
    localparam logic signed [66:0] LIM_LO     = -(67'sd32768 <<< 45);
    localparam logic signed [66:0] TRUNC_BIAS = (67'sd1 <<< 45) - 67'sd1;
    localparam logic [60:0]        NUMER_HI   = 61'd32767 << 45;
    localparam logic [60:0]        NUMER_LO   = 61'd1 << 60;

    typedef struct packed {
        logic [1:0]          operation;
        logic [2:0]          channel;
        logic signed [15:0]  sample_in;
        logic [3:0]          band;
        logic signed [23:0]  feedback_first;
        logic signed [23:0]  feedback_second;
        logic signed [23:0]  input_weight;
        logic signed [23:0]  band_gain;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          channel_out;
        logic signed [15:0]  sample_out;
        logic                clipped;
    } out_item_t;

    typedef struct packed {
        logic signed [23:0] a0;
        logic signed [23:0] a1;
        logic signed [23:0] b0;
        logic signed [23:0] gain;
    } coef_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_F_B0,
        MUL_D0_A0,
        MUL_D1_A1,
        MUL_D1_MA,
        MUL_M_GAIN,
        MUL_F_ATT,
        MUL_ATT_REC
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic              capture;
        logic              load_coef;
        logic              clear;
        logic              rd;
        logic              dlatch;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        logic              w_en;
        logic              f_en;
        logic              chk;
        logic              div_capture;
        logic              upd;
        logic [BIDX_W-1:0] band;
    } cmd_t;

    typedef struct packed {
        logic clip;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/graphic_equalizer_bandpass_cascade_top.sv
// Graphic equalizer top level: controller plus datapath.
// Depends on gebc_pkg, gebc_ctrl and gebc_datapath.
//
// Each sample request runs through the first active_bands band-pass sections of its
// channel, then through the channel attenuation with saturation and slow recovery.
// One request is worked on at a time. A sample runs the band schedule once per active
// band, then the attenuation steps; a clipped sample also waits for the iterative
// attenuation divide. The work per sample follows from the single shared multiplier
// (five products per band) and the registered read of the delay RAM. Load and clear
// requests, and ignored requests, are done in the idle state. A finished sample sits
// in the output register; the next request is taken while it waits, and the block only
// holds before writing a new result if the previous one has not been taken yet.
// Delay words are cleared at once by per-row valid bits, so reset and clear need no
// sweep. Configuration (active_bands) must be written only while the block is idle.
module graphic_equalizer_bandpass_cascade_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gebc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gebc_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data
);
    import gebc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the bands and decode each request
    gebc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sts         (sts),
        .cmd         (cmd)
    );

    // Hold coefficients, delays, attenuation and the result register
    gebc_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/gebc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gebc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 80
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/gebc_divider.sv
// Restoring divider, one quotient bit per cycle, for the attenuation update on clipping.
// Depends on gebc_pkg; the quotient is known to fit 32 bits.
module gebc_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [60:0] numer,
    input  logic [31:0] denom,
    output logic        done,
    output logic [31:0] quot
);
    import gebc_pkg::*;

    logic [31:0] rem_reg, q_reg, denom_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] trial, diff;
    logic        ge;

    assign trial = {rem_reg, q_reg[31]};
    assign ge    = trial >= {1'b0, denom_reg};
    assign diff  = trial - {1'b0, denom_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= {3'b000, numer[60:32]};
            q_reg     <= numer[31:0];
            denom_reg <= denom;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            q_reg   <= {q_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/gebc_datapath.sv
// Datapath: coefficient and attenuation registers, delay RAM, shared multiplier,
// accumulator, saturation and output register. Depends on gebc_pkg, gebc_ram, gebc_divider.
module gebc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gebc_pkg::in_item_t   s_data,
    input  gebc_pkg::cmd_t       cmd,
    output gebc_pkg::sts_t       sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gebc_pkg::out_item_t  m_data
);
    import gebc_pkg::*;

    coef_t              coef_reg [NUM_BANDS];
    logic [31:0]        atten_reg [NUM_CHANNELS];
    logic [ROWS-1:0]    row_valid_reg;
    logic [2:0]         ch_reg;
    logic [CIDX_W-1:0]  ch_idx;
    logic signed [31:0] f_reg, d0_reg, d1_reg, w_reg;
    logic signed [33:0] m_reg;
    logic signed [66:0] prod_reg;
    logic signed [59:0] acc_reg;
    logic [31:0]        atten_work_reg;
    logic signed [15:0] sample_reg;
    logic               clip_reg, rd_valid_reg, m_valid_reg;
    out_item_t          m_data_reg;

    coef_t              coef_cur;
    logic [ROW_AW-1:0]  row_addr;
    logic [63:0]        ram_rdata;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod_next, prod_sh18, prod_sh31, y_adj;
    logic signed [59:0] acc_sh;
    logic signed [31:0] w_next, f_next;
    logic signed [33:0] m_next;
    logic signed [15:0] sample_next;
    logic               clip_hi, clip_lo, div_start, div_done;
    logic [60:0]        div_numer;
    logic [31:0]        div_denom, div_quot, atten_rec;
    logic [32:0]        neg_f;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    assign ch_idx   = CIDX_W'(ch_reg);
    assign coef_cur = coef_reg[cmd.band];
    assign row_addr = ROW_AW'(ch_idx) * ROW_AW'(NUM_BANDS) + ROW_AW'(cmd.band);

    gebc_ram #(
        .WIDTH (64),
        .DEPTH (ROWS)
    ) u_delay_ram (
        .clk     (aclk),
        .wr_en   (cmd.f_en),
        .wr_addr (row_addr),
        .wr_data ({d0_reg, w_reg}),
        .rd_addr (row_addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        case (cmd.mul_sel)
            MUL_F_B0: begin
                mul_a = 34'(f_reg);
                mul_b = 33'(coef_cur.b0);
            end
            MUL_D0_A0: begin
                mul_a = 34'(d0_reg);
                mul_b = 33'(coef_cur.a0);
            end
            MUL_D1_A1: begin
                mul_a = 34'(d1_reg);
                mul_b = 33'(coef_cur.a1);
            end
            MUL_D1_MA: begin
                mul_a = 34'(d1_reg);
                mul_b = MA_SECOND_TAP;
            end
            MUL_M_GAIN: begin
                mul_a = m_reg;
                mul_b = 33'(coef_cur.gain);
            end
            MUL_F_ATT: begin
                mul_a = 34'(f_reg);
                mul_b = $signed({1'b0, atten_reg[ch_idx]});
            end
            MUL_ATT_REC: begin
                mul_a = $signed({2'b00, atten_work_reg});
                mul_b = $signed({1'b0, RECOVER_FACTOR});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_sh18 = prod_reg >>> 18;
    assign prod_sh31 = prod_reg >>> 31;
    assign acc_sh    = acc_reg >>> 18;
    assign w_next    = sat32(64'(acc_sh));
    assign m_next    = 34'(w_next) + 34'(prod_sh18);
    assign f_next    = sat32(64'(f_reg) + 64'(prod_sh18));

    assign clip_hi     = prod_reg > LIM_HI;
    assign clip_lo     = prod_reg < LIM_LO;
    assign y_adj       = prod_reg[66] ? prod_reg + TRUNC_BIAS : prod_reg;
    assign sample_next = 16'(y_adj >>> 45);
    assign neg_f       = 33'd0 - {f_reg[31], f_reg};
    assign div_numer   = clip_hi ? NUMER_HI : NUMER_LO;
    assign div_denom   = clip_hi ? f_reg : neg_f[31:0];
    assign div_start   = cmd.chk & (clip_hi | clip_lo);
    assign atten_rec   = (prod_sh31 > $signed({35'd0, UNITY_ATTEN})) ? UNITY_ATTEN
                                                                      : prod_sh31[31:0];

    gebc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_numer),
        .denom   (div_denom),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                atten_reg[c] <= UNITY_ATTEN;
            end
        end else begin
            if (cmd.clear) begin
                row_valid_reg <= '0;
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    atten_reg[c] <= UNITY_ATTEN;
                end
            end
            if (cmd.f_en) begin
                row_valid_reg[row_addr] <= 1'b1;
            end
            if (cmd.upd) begin
                atten_reg[ch_idx] <= atten_rec;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg <= s_data.channel;
            f_reg  <= 32'(s_data.sample_in) <<< 14;
        end
        if (cmd.load_coef) begin
            coef_reg[BIDX_W'(s_data.band)] <= '{a0:   s_data.feedback_first,
                                               a1:   s_data.feedback_second,
                                               b0:   s_data.input_weight,
                                               gain: s_data.band_gain};
        end
        if (cmd.rd) begin
            rd_valid_reg <= row_valid_reg[row_addr];
        end
        if (cmd.dlatch) begin
            d0_reg <= rd_valid_reg ? ram_rdata[31:0] : 32'sd0;
            d1_reg <= rd_valid_reg ? ram_rdata[63:32] : 32'sd0;
        end
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_reg[59:0];
            ACC_ADD:  acc_reg <= acc_reg + prod_reg[59:0];
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.w_en) begin
            w_reg <= w_next;
            m_reg <= m_next;
        end
        if (cmd.f_en) begin
            f_reg <= f_next;
        end
        if (cmd.chk) begin
            clip_reg <= clip_hi | clip_lo;
            if (clip_hi) begin
                sample_reg <= 16'sd32767;
            end else if (clip_lo) begin
                sample_reg <= -16'sd32768;
            end else begin
                sample_reg     <= sample_next;
                atten_work_reg <= atten_reg[ch_idx];
            end
        end
        if (cmd.div_capture) begin
            atten_work_reg <= div_quot;
        end
        if (cmd.upd) begin
            m_data_reg <= '{channel_out: ch_reg, sample_out: sample_reg, clipped: clip_reg};
        end
    end

    assign sts.clip     = clip_hi | clip_lo;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

>>> rtl/gebc_ctrl.sv
// Controller: request decode, band sequencing and the per-band multiply schedule.
// Depends on gebc_pkg; drives the datapath through cmd_t and reads sts_t.
module gebc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gebc_pkg::in_item_t s_data,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  gebc_pkg::sts_t     sts,
    output gebc_pkg::cmd_t     cmd
);
    import gebc_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_RD   = 14'b00000000000010,
        ST_M1   = 14'b00000000000100,
        ST_M2   = 14'b00000000001000,
        ST_M3   = 14'b00000000010000,
        ST_M4   = 14'b00000000100000,
        ST_W    = 14'b00000001000000,
        ST_M5   = 14'b00000010000000,
        ST_F    = 14'b00000100000000,
        ST_Y    = 14'b00001000000000,
        ST_CHK  = 14'b00010000000000,
        ST_DIV  = 14'b00100000000000,
        ST_REC  = 14'b01000000000000,
        ST_UPD  = 14'b10000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [BCNT_W-1:0] band_cnt_reg, band_cnt_next, nb;
    logic [3:0]        active_bands_reg;
    logic              ch_ok, band_ok;

    assign nb      = (32'(active_bands_reg) >= NUM_BANDS) ? BCNT_W'(NUM_BANDS)
                                                          : BCNT_W'(active_bands_reg);
    assign ch_ok   = 32'(s_data.channel) < NUM_CHANNELS;
    assign band_ok = 32'(s_data.band) < NUM_BANDS;

    always_comb begin
        cmd           = '0;
        cmd.mul_sel   = MUL_NONE;
        cmd.acc_op    = ACC_HOLD;
        cmd.band      = BIDX_W'(band_cnt_reg);
        state_next    = state_reg;
        band_cnt_next = band_cnt_reg;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.operation == OP_SAMPLE && ch_ok) begin
                        cmd.capture   = 1'b1;
                        band_cnt_next = '0;
                        state_next    = (nb == '0) ? ST_Y : ST_RD;
                    end
                    if (s_data.operation == OP_LOAD && band_ok) begin
                        cmd.load_coef = 1'b1;
                    end
                    if (s_data.operation == OP_CLEAR) begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_M1;
            end
            ST_M1: begin
                cmd.dlatch  = 1'b1;
                cmd.mul_sel = MUL_F_B0;
                state_next  = ST_M2;
            end
            ST_M2: begin
                cmd.mul_sel = MUL_D0_A0;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_M3;
            end
            ST_M3: begin
                cmd.mul_sel = MUL_D1_A1;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_M4;
            end
            ST_M4: begin
                cmd.mul_sel = MUL_D1_MA;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_W;
            end
            ST_W: begin
                cmd.w_en   = 1'b1;
                state_next = ST_M5;
            end
            ST_M5: begin
                cmd.mul_sel = MUL_M_GAIN;
                state_next  = ST_F;
            end
            ST_F: begin
                cmd.f_en      = 1'b1;
                band_cnt_next = band_cnt_reg + 1'b1;
                state_next    = (band_cnt_next == nb) ? ST_Y : ST_RD;
            end
            ST_Y: begin
                cmd.mul_sel = MUL_F_ATT;
                state_next  = ST_CHK;
            end
            ST_CHK: begin
                cmd.chk    = 1'b1;
                state_next = sts.clip ? ST_DIV : ST_REC;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    cmd.div_capture = 1'b1;
                    state_next      = ST_REC;
                end
            end
            ST_REC: begin
                cmd.mul_sel = MUL_ATT_REC;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                if (sts.out_free) begin
                    cmd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            band_cnt_reg     <= '0;
            active_bands_reg <= ACTIVE_BANDS_RESET;
        end else begin
            state_reg    <= state_next;
            band_cnt_reg <= band_cnt_next;
            if (cfg_wr_en) begin
                active_bands_reg <= cfg_wr_data;
            end
        end
    end

endmodule

>>> rtl/gebc_checker.sv
// Port-level checks of the equalizer top level, attached by bind.
// Depends on gebc_pkg and graphic_equalizer_bandpass_cascade_top.
module gebc_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input gebc_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input gebc_pkg::out_item_t m_data
);
    import gebc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // Drive a saturated value whenever clipping is flagged
    a_clip_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clipped |->
            m_data.sample_out == 16'sh7FFF || m_data.sample_out == 16'sh8000)
        else $error("clipped flag without saturated sample");

    // Drop ready after an accepted sample request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == OP_SAMPLE &&
            32'(s_data.channel) < NUM_CHANNELS |=> !s_ready)
        else $error("ready stayed high while a sample is in work");

    // Clear the result channel in reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind graphic_equalizer_bandpass_cascade_top gebc_port_checker u_gebc_checker (.*);

>>> sim/gebc_checker.sv
`timescale 1ns / 1ps
// Checker for the band-pass cascade equalizer: watches the input and output streams, predicts results.
// Depends on gebc_pkg; instantiated by tb_top beside the block.
module gebc_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  gebc_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  gebc_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data,
    output int                  fail_count,
    output int                  pending
);
    import gebc_pkg::*;

    localparam logic signed [63:0] MA2 = -64'sd263455;

    coef_t                  coefs [NUM_BANDS];
    logic signed [63:0]     dly0 [NUM_CHANNELS][NUM_BANDS];
    logic signed [63:0]     dly1 [NUM_CHANNELS][NUM_BANDS];
    logic [63:0]            att [NUM_CHANNELS];
    logic [3:0]             bands_on;
    out_item_t              eq_queue [$];

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic clear_all();
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            att[c] = 64'd2147483648;
            for (int b = 0; b < NUM_BANDS; b++) begin
                dly0[c][b] = 0;
                dly1[c][b] = 0;
            end
        end
    endtask

    task automatic predict_equalized(in_item_t it);
        logic signed [63:0] f, w, m, y;
        logic [63:0]        a;
        int                 nb;
        out_item_t          r;
        r = '0;
        case (it.operation)
            OP_LOAD: begin
                if (it.band < NUM_BANDS)
                    coefs[it.band] = '{it.feedback_first, it.feedback_second,
                                       it.input_weight, it.band_gain};
            end
            OP_CLEAR: clear_all();
            OP_SAMPLE: begin
                nb = (bands_on < NUM_BANDS) ? bands_on : NUM_BANDS;
                f = 64'(it.sample_in) * 64'sd16384;
                for (int k = 0; k < nb; k++) begin
                    // >>> on a signed value floors, as the arithmetic needs
                    w = clamp32((f * 64'(coefs[k].b0) + dly0[it.channel][k] * 64'(coefs[k].a0)
                                 + dly1[it.channel][k] * 64'(coefs[k].a1)) >>> 18);
                    m = (w * 64'sd262144 + dly1[it.channel][k] * MA2) >>> 18;
                    f = clamp32(f + ((m * 64'(coefs[k].gain)) >>> 18));
                    dly1[it.channel][k] = dly0[it.channel][k];
                    dly0[it.channel][k] = w;
                end
                a = att[it.channel];
                y = f * $signed(a);
                r.channel_out = it.channel;
                if (y > (64'sd32767 <<< 45)) begin
                    a = (64'd32767 << 45) / 64'(f);
                    r.sample_out = 16'sd32767;
                    r.clipped = 1'b1;
                end else if (y < -(64'sd32768 <<< 45)) begin
                    a = (64'd1 << 60) / 64'(-f);
                    r.sample_out = -16'sd32768;
                    r.clipped = 1'b1;
                end else begin
                    r.sample_out = 16'(y / (64'sd1 <<< 45));
                end
                a = (a * 64'd2147498251) >> 31;
                if (a > 64'd2147483648) a = 64'd2147483648;
                att[it.channel] = a;
                eq_queue.push_back(r);
            end
            default: ;
        endcase
    endtask

    assign pending = eq_queue.size();

    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            clear_all();
            bands_on <= ACTIVE_BANDS_RESET;
            eq_queue.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) bands_on <= cfg_wr_data;
            if (m_valid && m_ready) begin
                if (eq_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result %p", m_data);
                end else begin
                    e = eq_queue.pop_front();
                    if (e !== m_data) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", e, m_data);
                    end
                end
            end
            if (s_valid && s_ready) predict_equalized(s_data);
        end
    end

    initial fail_count = 0;
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the band-pass cascade equalizer: stimulus, idling and verdict.
// Depends on gebc_pkg, gebc_checker and the block's top level.
module tb_top;
    import gebc_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int IN_W        = $bits(in_item_t);

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 0;
    out_item_t  m_data;
    logic       cfg_wr_en = 0;
    logic [3:0] cfg_wr_data = '0;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         rx_mode = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    graphic_equalizer_bandpass_cascade_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    gebc_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: switch between always-ready, random stalls and long stalls
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // Watchdog: count cycles without any accepted request, taken result or configuration write
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold one request until accepted; valid stays high, and the caller drops it
    task automatic send(in_item_t it);
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_coef(int style);
        logic signed [23:0] v;
        v = 24'($urandom);
        // mostly tame values near the usual range, sometimes the full field
        if (style != 0) v = 24'($signed(v) >>> $urandom_range(4, 10));
        return v;
    endfunction

    function automatic in_item_t load_item(int b, int style);
        in_item_t it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_LOAD;
        it.band = 4'(b);
        it.feedback_first = rand_coef(style);
        it.feedback_second = rand_coef(style);
        it.input_weight = rand_coef(style);
        it.band_gain = rand_coef(style);
        return it;
    endfunction

    function automatic in_item_t sample_item(logic signed [15:0] x);
        in_item_t it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_SAMPLE;
        it.channel = 3'($urandom);
        it.sample_in = x;
        return it;
    endfunction

    // Wait for every result, cover the latency of a trailing load or clear, then write the band count
    task automatic drain_and_config(logic [3:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        in_item_t it;
        int       burst;
        logic [3:0] band_cfg [6] = '{4'd10, 4'd0, 4'd15, 4'd1, 4'd5, 4'd11};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: load every band, band 0 with extremes, then edge samples
        for (int b = 0; b < NUM_BANDS; b++) begin
            it = load_item(b, 0);
            if (b == 0) begin
                it.feedback_first = 24'sh7FFFFF; it.feedback_second = 24'sh800000;
                it.input_weight = 24'sh7FFFFF; it.band_gain = 24'sh7FFFFF;
            end
            send(it);
        end
        it = load_item(12, 0);                  // band out of range: ignored
        send(it);
        send(sample_item(16'sh7FFF));
        send(sample_item(-16'sh8000));
        send(sample_item(16'sh0000));
        send(sample_item(-16'sh0001));
        it = sample_item(16'sh1234); it.channel = 3'd7; send(it);
        it = sample_item(16'sh7FFF); it.operation = OP_RESERVED; send(it);   // unknown op
        it = sample_item(0); it.operation = OP_CLEAR; send(it);
        send(sample_item(16'sh7FFF));
        send(sample_item(-16'sh8000));

        // Random phases at several band counts, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_config(band_cfg[ph]);
            // reload mostly tame coefficients so most samples stay in range
            for (int b = 0; b < NUM_BANDS; b++) send(load_item(b, ($urandom_range(0, 3) != 0)));
            for (int n = 0; n < 135; ) begin
                burst = $urandom_range(1, 20);
                for (int j = 0; j < burst; j++) begin
                    case ($urandom_range(0, 39))
                        0: begin it = sample_item(0); it.operation = OP_CLEAR; end
                        1: it = load_item($urandom_range(0, 15), 1);
                        2: begin it = sample_item(0); it.operation = OP_RESERVED; end
                        3: it = sample_item($urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000);
                        default: it = sample_item(16'($urandom));
                    endcase
                    send(it);
                    n++;
                end
                if ($urandom_range(0, 2) != 0) pause();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/gebc_pkg.sv
rtl/gebc_ram.sv
rtl/gebc_divider.sv
rtl/gebc_datapath.sv
rtl/gebc_ctrl.sv
rtl/graphic_equalizer_bandpass_cascade_top.sv
rtl/gebc_checker.sv
sim/gebc_checker.sv
sim/tb_top.sv
